@@ design/rrtd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrtd_pkg
// Shared types and codes for the round robin task dispatcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrtd_pkg;

  // request kinds
  localparam logic [2:0] KIND_RESUME   = 3'd0;
  localparam logic [2:0] KIND_SUSPEND  = 3'd1;
  localparam logic [2:0] KIND_LEAVE    = 3'd2;
  localparam logic [2:0] KIND_SLEEP    = 3'd3;
  localparam logic [2:0] KIND_SCHEDULE = 3'd4;
  localparam logic [2:0] KIND_TICK     = 3'd5;
  localparam logic [2:0] KIND_QUERY    = 3'd6;

  // task states
  localparam logic [1:0] TS_SUSPENDED = 2'd0;
  localparam logic [1:0] TS_RESUMED   = 2'd1;
  localparam logic [1:0] TS_RUNNING   = 2'd2;
  localparam logic [1:0] TS_SLEEPING  = 2'd3;

  localparam int unsigned CFG_W = 7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  handle;
    logic        self_target;
    logic [7:0]  argument;
    logic [14:0] sleep_ticks;
  } rrtd_req_t;

  typedef struct packed {
    logic       dispatched;
    logic [5:0] dispatched_task;
    logic [7:0] dispatched_arg;
    logic [1:0] queried_state;
    logic [7:0] queried_arg;
    logic       status;
  } rrtd_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic take;        // latch accepted request
    logic exec;        // single-cycle table update
    logic q_read;      // read entry at handle
    logic q_res;       // form query result
    logic sched_none;  // schedule with no tasks installed
    logic scan_start;  // set up scan pointers
    logic scan_step;   // issue one read, evaluate one entry
    logic out_load;    // move result into output register
  } rrtd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] kind;
    logic       cnt_zero;
    logic       scan_hit;
    logic       scan_end;
    logic       out_free;
  } rrtd_sts_t;

endpackage

`default_nettype wire

@@ design/rrtd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrtd_ctrl
// Sequencer: accepts a request, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrtd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rrtd_pkg::rrtd_sts_t sts,
  output rrtd_pkg::rrtd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QRES,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.kind)
          rrtd_pkg::KIND_QUERY: begin
            cmd.q_read = 1'b1;
            state_nxt  = S_QRES;
          end
          rrtd_pkg::KIND_SCHEDULE: begin
            if (sts.cnt_zero) begin
              cmd.sched_none = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_QRES: begin
        cmd.q_res = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/rrtd_dpath.sv @@
// ----------------------------------------------------------------------------
// rrtd_dpath
// Task tables, scan pointers, timer and result/output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrtd_dpath #(
  parameter int unsigned MAX_TASKS = 64,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  rrtd_pkg::rrtd_req_t         in_data,
  input  wire                         cfg_we,
  input  wire [rrtd_pkg::CFG_W-1:0]   cfg_data,
  input  rrtd_pkg::rrtd_cmd_t         cmd,
  output rrtd_pkg::rrtd_sts_t         sts,
  input  wire                         out_stall,
  output logic                        out_valid,
  output rrtd_pkg::rrtd_rsp_t         out_data
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned CW    = (CNT_W > rrtd_pkg::CFG_W) ? CNT_W : rrtd_pkg::CFG_W;
  localparam int unsigned HX_W  = (IDX_W > 6) ? IDX_W : 6;
  localparam int unsigned TS_W  = (TIME_BITS > 15) ? TIME_BITS + 1 : 16;

  // storage
  logic [1:0]           st_mem_r  [MAX_TASKS];
  logic [7:0]           arg_mem_r [MAX_TASKS];
  logic [TIME_BITS-1:0] dl_mem_r  [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r;

  logic [rrtd_pkg::CFG_W-1:0] task_count_r;
  logic [TIME_BITS-1:0]       time_r;
  logic [IDX_W-1:0]           cur_r;
  logic                       has_cur_r;
  rrtd_pkg::rrtd_req_t        req_r;
  rrtd_pkg::rrtd_rsp_t        res_r;
  rrtd_pkg::rrtd_rsp_t        res_nxt;
  rrtd_pkg::rrtd_rsp_t        out_r;
  logic                       out_vld_r;

  // read port registers
  logic [1:0]           st_rd_r;
  logic [7:0]           arg_rd_r;
  logic [TIME_BITS-1:0] dl_rd_r;
  logic                 vld_rd_r;

  // scan
  logic [IDX_W-1:0] iss_idx_r;
  logic [CNT_W-1:0] iss_left_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             pv_r;
  logic             last_r;

  // combinational
  logic [CW-1:0]        tc_x, cnt_c;
  logic [CNT_W-1:0]     cnt;
  logic [HX_W-1:0]      hx;
  logic [IDX_W-1:0]     haddr;
  logic                 handle_ok, cur_ok, use_cur, tgt_ok;
  logic [IDX_W-1:0]     tgt_idx, ra, wa;
  logic                 st_we, arg_we, dl_we, time_inc, exec_bad;
  logic [1:0]           st_wd;
  logic [TS_W-1:0]      dl_sum;
  logic [TIME_BITS-1:0] deadline, diff;
  logic [1:0]           st_eff;
  logic                 eligible;
  logic [HX_W-1:0]      rd_idx_x;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] p;
    p = CNT_W'(idx) + CNT_W'(1);
    next_idx = (p >= n) ? '0 : p[IDX_W-1:0];
  endfunction

  assign tc_x      = CW'(task_count_r);
  assign cnt_c     = (tc_x > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : tc_x;
  assign cnt       = cnt_c[CNT_W-1:0];
  assign hx        = HX_W'(req_r.handle);
  assign haddr     = hx[IDX_W-1:0];
  assign handle_ok = CW'(req_r.handle) < cnt_c;
  assign cur_ok    = has_cur_r && (CW'(cur_r) < cnt_c);

  assign use_cur = (req_r.kind == rrtd_pkg::KIND_LEAVE) ||
                   (((req_r.kind == rrtd_pkg::KIND_SUSPEND) ||
                     (req_r.kind == rrtd_pkg::KIND_SLEEP)) && req_r.self_target);
  assign tgt_ok  = use_cur ? cur_ok : handle_ok;
  assign tgt_idx = use_cur ? cur_r : haddr;

  assign dl_sum   = TS_W'(time_r) + TS_W'(req_r.sleep_ticks);
  assign deadline = dl_sum[TIME_BITS-1:0];

  // wrap-safe expiry: due when time - deadline lands in the lower half
  assign st_eff   = vld_rd_r ? st_rd_r : rrtd_pkg::TS_SUSPENDED;
  assign diff     = time_r - dl_rd_r;
  assign eligible = (st_eff == rrtd_pkg::TS_RESUMED) ||
                    ((st_eff == rrtd_pkg::TS_SLEEPING) && !diff[TIME_BITS-1]);
  assign rd_idx_x = HX_W'(rd_idx_r);

  assign ra = cmd.scan_step ? iss_idx_r : haddr;
  assign wa = cmd.scan_step ? rd_idx_r : tgt_idx;

  always_comb begin
    st_we    = 1'b0;
    arg_we   = 1'b0;
    dl_we    = 1'b0;
    time_inc = 1'b0;
    st_wd    = rrtd_pkg::TS_RUNNING;
    if (cmd.exec) begin
      case (req_r.kind)
        rrtd_pkg::KIND_RESUME: begin
          st_we  = tgt_ok;
          arg_we = tgt_ok;
          st_wd  = rrtd_pkg::TS_RESUMED;
        end
        rrtd_pkg::KIND_LEAVE: begin
          st_we  = tgt_ok;
          arg_we = tgt_ok;
          st_wd  = rrtd_pkg::TS_RESUMED;
        end
        rrtd_pkg::KIND_SUSPEND: begin
          st_we = tgt_ok;
          st_wd = rrtd_pkg::TS_SUSPENDED;
        end
        rrtd_pkg::KIND_SLEEP: begin
          st_we = tgt_ok;
          dl_we = tgt_ok;
          st_wd = rrtd_pkg::TS_SLEEPING;
        end
        rrtd_pkg::KIND_TICK: time_inc = 1'b1;
        default: ;
      endcase
    end else if (cmd.scan_step && pv_r && eligible) begin
      st_we = 1'b1;
      st_wd = rrtd_pkg::TS_RUNNING;
    end
  end

  always_comb begin
    case (req_r.kind) inside
      rrtd_pkg::KIND_RESUME, rrtd_pkg::KIND_SUSPEND,
      rrtd_pkg::KIND_LEAVE, rrtd_pkg::KIND_SLEEP: exec_bad = !tgt_ok;
      rrtd_pkg::KIND_TICK:                        exec_bad = 1'b0;
      default:                                    exec_bad = 1'b1;
    endcase
  end

  // next result
  always_comb begin
    res_nxt = res_r;
    if (cmd.exec) begin
      res_nxt        = '0;
      res_nxt.status = exec_bad;
    end else if (cmd.q_res) begin
      res_nxt = '0;
      if (handle_ok) begin
        res_nxt.queried_state = st_eff;
        res_nxt.queried_arg   = arg_rd_r;
      end else begin
        res_nxt.status = 1'b1;
      end
    end else if (cmd.sched_none) begin
      res_nxt = '0;
    end else if (cmd.scan_step && pv_r && (eligible || last_r)) begin
      res_nxt = '0;
      if (eligible) begin
        res_nxt.dispatched      = 1'b1;
        res_nxt.dispatched_task = rd_idx_x[5:0];
        res_nxt.dispatched_arg  = arg_rd_r;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem_r[wa] <= st_wd;
    end
    if (arg_we) begin
      arg_mem_r[wa] <= req_r.argument;
    end
    if (dl_we) begin
      dl_mem_r[wa] <= deadline;
    end
    st_rd_r  <= st_mem_r[ra];
    arg_rd_r <= arg_mem_r[ra];
    dl_rd_r  <= dl_mem_r[ra];
    vld_rd_r <= vld_r[ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
      time_r       <= '0;
      cur_r        <= IDX_W'(MAX_TASKS - 1);
      has_cur_r    <= 1'b0;
      vld_r        <= '0;
      pv_r         <= 1'b0;
      iss_left_r   <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        task_count_r <= cfg_data;
        cur_r        <= IDX_W'(MAX_TASKS - 1);
        has_cur_r    <= 1'b0;
        vld_r        <= '0;
      end else begin
        if (st_we) begin
          vld_r[wa] <= 1'b1;
        end
        if (cmd.scan_step && pv_r) begin
          cur_r <= rd_idx_r;
          if (eligible) begin
            has_cur_r <= 1'b1;
          end
        end
      end
      if (time_inc) begin
        time_r <= time_r + TIME_BITS'(1);
      end
      if (cmd.scan_start) begin
        pv_r       <= 1'b0;
        iss_left_r <= cnt;
      end else if (cmd.scan_step) begin
        pv_r <= (iss_left_r != '0);
        if (iss_left_r != '0) begin
          iss_left_r <= iss_left_r - CNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= in_data;
    end
    if (cmd.scan_start) begin
      iss_idx_r <= next_idx(cur_r, cnt);
    end else if (cmd.scan_step && (iss_left_r != '0)) begin
      iss_idx_r <= next_idx(iss_idx_r, cnt);
      rd_idx_r  <= iss_idx_r;
      last_r    <= (iss_left_r == CNT_W'(1));
    end
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign sts.kind     = req_r.kind;
  assign sts.cnt_zero = (cnt == '0);
  assign sts.scan_hit = pv_r && eligible;
  assign sts.scan_end = pv_r && last_r && !eligible;
  assign sts.out_free = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ design/round_robin_task_dispatcher_core.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_dispatcher_core
// Flow: a request is accepted in IDLE, runs EXEC, then QRES for a query or
//   SCAN for a schedule (one entry read per cycle), then DONE loads out_r.
// A new request is taken only back in IDLE, after DONE; the single table
//   read port paces the scan.
// Reset: synchronous rst_n; all tasks suspended, count 0, timer 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Structure
//   rrtd_ctrl  - FSM: IDLE -> EXEC -> (QRES | SCAN | none) -> DONE -> IDLE.
//   rrtd_dpath - state/arg/deadline tables, timer, scan pointers, result reg.
//
// Table state is kept in a RAM plus one valid bit per entry; a clear valid
// bit reads as suspended, so reset and a task_count write clear the whole
// table by clearing the valid bits. Args and deadlines are never cleared.
//
// Schedule walks entries round robin from the task after the last one
// visited. Reads are pipelined: a new entry is read every cycle while the
// previous read is checked. First eligible entry (resumed, or sleeping and
// due) becomes running and ends the walk; an empty walk still leaves the
// pointer on the last entry looked at.
//
// The output register lets a new request come in while a result is still
// waiting on out_stall.

module round_robin_task_dispatcher_core #(
  parameter int unsigned MAX_TASKS = 64,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // request channel
  input  wire                       in_valid,
  output logic                      in_stall,
  input  rrtd_pkg::rrtd_req_t       in_data,
  // result channel
  output logic                      out_valid,
  input  wire                       out_stall,
  output rrtd_pkg::rrtd_rsp_t       out_data,
  // task_count register
  input  wire                       cfg_we,
  input  wire [rrtd_pkg::CFG_W-1:0] cfg_data
);

  rrtd_pkg::rrtd_cmd_t cmd;
  rrtd_pkg::rrtd_sts_t sts;

  rrtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrtd_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round robin task dispatcher. A queue of
// requests (directed first, then random per task_count setting) feeds a
// clocked driver; each accepted request runs through a local scheduler
// model whose response is queued and compared field by field by a clocked
// monitor. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------

module tb_top;

  // kind 7 has no package name; the block must flag it
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned CNT_W = rrtd_pkg::CFG_W;
  // worst request is a full 64 entry scan plus output stalls; this limit
  // only trips on a real hang
  localparam int unsigned HANG_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rrtd_pkg::rrtd_req_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rrtd_pkg::rrtd_rsp_t  out_data;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_data = '0;

  always #6 clk = ~clk;

  round_robin_task_dispatcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Scheduler model: task table, running pointer and tick counter
  // --------------------------------------------------------------------------
  logic [1:0]  slot_state [NUM_SLOTS];
  logic [7:0]  slot_arg   [NUM_SLOTS];
  logic [15:0] slot_wake  [NUM_SLOTS];
  logic [5:0]  run_idx = 6'd63;
  bit          run_valid = 1'b0;
  logic [15:0] tick_now = 16'd0;
  int unsigned installed = 0;

  rrtd_pkg::rrtd_req_t req_pending [$];
  rrtd_pkg::rrtd_rsp_t rsp_expected [$];
  rrtd_pkg::rrtd_rsp_t rsp_want;
  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // request generator bookkeeping: which slots ever had an argument stored,
  // and the task count in force while a phase is being built
  bit          arg_set [NUM_SLOTS];
  int unsigned gen_installed = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_state[i] = rrtd_pkg::TS_SUSPENDED;
      slot_arg[i]   = 8'd0;
      slot_wake[i]  = 16'd0;
      arg_set[i]    = 1'b0;
    end
  end

  // count write: every task back to suspended, scan restarts at task 0;
  // arguments, deadlines and the tick counter survive
  function automatic void install_tasks(logic [CNT_W-1:0] value);
    installed = (value > NUM_SLOTS) ? NUM_SLOTS : value;
    for (int i = 0; i < NUM_SLOTS; i++) slot_state[i] = rrtd_pkg::TS_SUSPENDED;
    run_idx   = 6'd63;
    run_valid = 1'b0;
  endfunction

  function automatic rrtd_pkg::rrtd_rsp_t predict_dispatch(rrtd_pkg::rrtd_req_t r);
    rrtd_pkg::rrtd_rsp_t o;
    bit          hdl_ok;
    bit          run_ok;
    logic [5:0]  tgt;
    logic [5:0]  nxt;
    logic [15:0] lag;
    int unsigned i;
    o      = '0;
    hdl_ok = r.handle < installed;
    run_ok = run_valid && (run_idx < installed);
    case (r.kind)
      rrtd_pkg::KIND_RESUME: begin
        if (hdl_ok) begin
          slot_state[r.handle] = rrtd_pkg::TS_RESUMED;
          slot_arg[r.handle]   = r.argument;
        end else begin
          o.status = 1'b1;
        end
      end
      rrtd_pkg::KIND_SUSPEND, rrtd_pkg::KIND_SLEEP: begin
        if (r.self_target ? !run_ok : !hdl_ok) begin
          o.status = 1'b1;
        end else begin
          tgt = r.self_target ? run_idx : r.handle;
          if (r.kind == rrtd_pkg::KIND_SUSPEND) begin
            slot_state[tgt] = rrtd_pkg::TS_SUSPENDED;
          end else begin
            slot_state[tgt] = rrtd_pkg::TS_SLEEPING;
            slot_wake[tgt]  = tick_now + {1'b0, r.sleep_ticks};
          end
        end
      end
      rrtd_pkg::KIND_LEAVE: begin
        if (run_ok) begin
          slot_arg[run_idx]   = r.argument;
          slot_state[run_idx] = rrtd_pkg::TS_RESUMED;
        end else begin
          o.status = 1'b1;
        end
      end
      rrtd_pkg::KIND_SCHEDULE: begin
        // pointer moves once per visited entry, even on an empty pass
        for (i = 0; i < installed && !o.dispatched; i++) begin
          nxt     = (int'(run_idx) + 1 >= installed) ? 6'd0 : run_idx + 6'd1;
          run_idx = nxt;
          // wrap-safe due test: deadline reached when now - wake is "positive"
          lag = tick_now - slot_wake[nxt];
          if (slot_state[nxt] == rrtd_pkg::TS_RESUMED ||
              (slot_state[nxt] == rrtd_pkg::TS_SLEEPING && !lag[15])) begin
            slot_state[nxt]   = rrtd_pkg::TS_RUNNING;
            run_valid         = 1'b1;
            o.dispatched      = 1'b1;
            o.dispatched_task = nxt;
            o.dispatched_arg  = slot_arg[nxt];
          end
        end
      end
      rrtd_pkg::KIND_TICK: begin
        tick_now = tick_now + 16'd1;
      end
      rrtd_pkg::KIND_QUERY: begin
        if (hdl_ok) begin
          o.queried_state = slot_state[r.handle];
          o.queried_arg   = slot_arg[r.handle];
        end else begin
          o.status = 1'b1;
        end
      end
      default: begin
        o.status = 1'b1;
      end
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request building
  // --------------------------------------------------------------------------
  function automatic rrtd_pkg::rrtd_req_t mk_req(logic [2:0] kind, logic [5:0] hdl,
                                                 logic self_t, logic [7:0] arg,
                                                 logic [14:0] ticks);
    rrtd_pkg::rrtd_req_t r;
    r.kind        = kind;
    r.handle      = hdl;
    r.self_target = self_t;
    r.argument    = arg;
    r.sleep_ticks = ticks;
    return r;
  endfunction

  // A slot whose argument was never stored must not be queried or put to
  // sleep by handle (a sleeper can later be dispatched and report its
  // argument); such a request becomes a resume, which stores one. Running
  // and resumed slots always went through a store, so self-targeted and
  // leave requests need no guard.
  function automatic void queue_request(rrtd_pkg::rrtd_req_t r);
    if ((r.kind == rrtd_pkg::KIND_QUERY ||
         (r.kind == rrtd_pkg::KIND_SLEEP && !r.self_target)) &&
        r.handle < gen_installed && !arg_set[r.handle]) begin
      r.kind = rrtd_pkg::KIND_RESUME;
    end
    if (r.kind == rrtd_pkg::KIND_RESUME && r.handle < gen_installed) begin
      arg_set[r.handle] = 1'b1;
    end
    req_pending.push_back(r);
  endfunction

  // Random requests biased toward real scheduling traffic: lots of resume,
  // schedule and self-targeted leave/sleep on mostly valid handles, short
  // sleeps so sleepers come due, with some noise (any handle, long sleeps,
  // unknown kind) mixed in.
  task automatic gen_random(int unsigned n);
    rrtd_pkg::rrtd_req_t r;
    int unsigned roll;
    for (int unsigned k = 0; k < n; k++) begin
      r = rrtd_pkg::rrtd_req_t'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0 || gen_installed == 0) begin
        r.handle = 6'($urandom_range(0, 63));
      end else begin
        r.handle = 6'($urandom_range(0, gen_installed - 1));
      end
      roll = $urandom_range(0, 9);
      if (roll < 5)      r.sleep_ticks = 15'($urandom_range(0, 3));
      else if (roll < 8) r.sleep_ticks = 15'($urandom_range(0, 40));
      else               r.sleep_ticks = 15'($urandom_range(0, 32767));
      roll = $urandom_range(0, 99);
      if (roll < 18)      r.kind = rrtd_pkg::KIND_RESUME;
      else if (roll < 26) r.kind = rrtd_pkg::KIND_SUSPEND;
      else if (roll < 38) r.kind = rrtd_pkg::KIND_LEAVE;
      else if (roll < 50) r.kind = rrtd_pkg::KIND_SLEEP;
      else if (roll < 74) r.kind = rrtd_pkg::KIND_SCHEDULE;
      else if (roll < 88) r.kind = rrtd_pkg::KIND_TICK;
      else if (roll < 97) r.kind = rrtd_pkg::KIND_QUERY;
      else                r.kind = KIND_UNKNOWN;
      if (r.kind == rrtd_pkg::KIND_SUSPEND || r.kind == rrtd_pkg::KIND_SLEEP) begin
        r.self_target = ($urandom_range(0, 9) < 7);
      end
      queue_request(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued requests, predicts each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        rsp_expected.push_back(predict_dispatch(in_data));
      end
      // payload holds while stalled; otherwise pick next request or a gap
      if (!in_valid || !in_stall) begin
        if (req_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares each accepted response with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_expected.size() == 0) begin
          $error("response with no request outstanding");
          error_count++;
        end else begin
          rsp_want = rsp_expected.pop_front();
          check_field("dispatched", rsp_want.dispatched, out_data.dispatched);
          check_field("dispatched_task", rsp_want.dispatched_task, out_data.dispatched_task);
          check_field("dispatched_arg", rsp_want.dispatched_arg, out_data.dispatched_arg);
          check_field("queried_state", rsp_want.queried_state, out_data.queried_state);
          check_field("queried_arg", rsp_want.queried_arg, out_data.queried_arg);
          check_field("status", rsp_want.status, out_data.status);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // hang detector: any handshake or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // everything sent and every response back; checked mid-cycle so all
  // edge updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (req_pending.size() != 0 || in_valid || rsp_expected.size() != 0);
  endtask

  task automatic write_task_count(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    install_tasks(value);
    gen_installed = (value > NUM_SLOTS) ? NUM_SLOTS : value;
  endtask

  initial begin
    int unsigned count_plan [12];
    int unsigned gap_plan   [4];
    int unsigned hold_plan  [4];
    count_plan = '{5, 127, 3, 0, 8, 64, 2, 1, 6, 65, 16, 4};
    gap_plan   = '{0, 48, 0, 33};
    hold_plan  = '{0, 0, 48, 33};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // nothing installed out of reset: empty schedule, invalid handles
    queue_request(mk_req(rrtd_pkg::KIND_SCHEDULE, 6'd0, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_RESUME, 6'd0, 1'b0, 8'h11, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_QUERY, 6'd0, 1'b0, 8'h00, 15'd0));
    wait_drained();

    // directed pass with four tasks
    write_task_count(7'd4);
    queue_request(mk_req(rrtd_pkg::KIND_QUERY, 6'd63, 1'b0, 8'h00, 15'd0));   // bad handle
    queue_request(mk_req(rrtd_pkg::KIND_RESUME, 6'd0, 1'b0, 8'hFF, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_RESUME, 6'd3, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_LEAVE, 6'd0, 1'b0, 8'h22, 15'd0));    // nobody running
    queue_request(mk_req(rrtd_pkg::KIND_SUSPEND, 6'd0, 1'b1, 8'h00, 15'd0));  // nobody running
    queue_request(mk_req(rrtd_pkg::KIND_SLEEP, 6'd0, 1'b1, 8'h00, 15'd5));    // nobody running
    queue_request(mk_req(rrtd_pkg::KIND_SCHEDULE, 6'd0, 1'b0, 8'h00, 15'd0)); // picks task 0
    queue_request(mk_req(rrtd_pkg::KIND_QUERY, 6'd0, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_LEAVE, 6'd0, 1'b0, 8'h5A, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_SLEEP, 6'd3, 1'b0, 8'h00, 15'h7FFF)); // far deadline
    queue_request(mk_req(rrtd_pkg::KIND_SCHEDULE, 6'd0, 1'b0, 8'h00, 15'd0)); // wraps to 0
    queue_request(mk_req(rrtd_pkg::KIND_SLEEP, 6'd0, 1'b1, 8'h00, 15'd0));    // due at once
    queue_request(mk_req(rrtd_pkg::KIND_SCHEDULE, 6'd0, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_SUSPEND, 6'd0, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_SCHEDULE, 6'd0, 1'b0, 8'h00, 15'd0)); // empty pass
    queue_request(mk_req(KIND_UNKNOWN, 6'd63, 1'b1, 8'hFF, 15'h7FFF));
    queue_request(mk_req(rrtd_pkg::KIND_RESUME, 6'd4, 1'b0, 8'h33, 15'd0));   // just past count
    queue_request(mk_req(rrtd_pkg::KIND_QUERY, 6'd3, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_TICK, 6'd0, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_RESUME, 6'd2, 1'b0, 8'hA5, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_SUSPEND, 6'd2, 1'b0, 8'h00, 15'd0));
    queue_request(mk_req(rrtd_pkg::KIND_QUERY, 6'd2, 1'b0, 8'h00, 15'd0));
    wait_drained();

    // random phases: count settings incl. zero, full and oversized,
    // cycling through gap/stall modes
    for (int p = 0; p < 12; p++) begin
      idle_pct  = gap_plan[p % 4];
      stall_pct = hold_plan[p % 4];
      write_task_count(CNT_W'(count_plan[p]));
      gen_random((count_plan[p] == 0) ? 40 : 155);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ round_robin_task_dispatcher_core.f @@
design/rrtd_pkg.sv
design/rrtd_ctrl.sv
design/rrtd_dpath.sv
design/round_robin_task_dispatcher_core.sv
tb/sv/tb_top.sv
